>>> design/periodic_task_dispatcher_top_defines.svh
// ----------------------------------------------------------------------------
// Periodic task dispatcher assertion macros
// Clocked assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_TOP_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_DEFINES_SVH

// Property checked while the block is out of reset.
`define PDT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pdt assertion failed");

// Property that also holds across reset.
`define PDT_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("pdt reset assertion failed");

`endif

>>> design/pdt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher package
// Types, codes and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package pdt_pkg;

    localparam int MAX_SLOTS    = 8;
    localparam int SLOT_W       = $clog2(MAX_SLOTS);
    localparam int CNT_W        = $clog2(MAX_SLOTS + 1);
    localparam int MS_TO_US     = 1000;
    localparam int PCT_FULL     = 100;
    localparam int LATE_PERIODS = 3;
    localparam int WIN_MIN_MS   = 1000;
    localparam int PCT_W        = 7;
    localparam int PROD_W       = 32 + PCT_W;

    typedef enum logic [2:0] {
        OP_POLL   = 3'd0,
        OP_FINISH = 3'd1,
        OP_WINDOW = 3'd2,
        OP_ADD    = 3'd3,
        OP_SETPER = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic fin1;
        logic fin2;
        logic wmul;
        logic w101;
        logic wcmp;
        logic div;
        logic publish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic id_valid;
        logic scan_done;
        logic win_short;
        logic win_fin;
        logic div_last;
        logic out_busy;
    } t_sts;

endpackage

>>> design/pdt_if.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher channels
// Valid/ready channels for the op beat and the result beat.
// ----------------------------------------------------------------------------
interface pdt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic [2:0]  task_id;
    logic [31:0] elapsed_us;
    logic [15:0] interval_ms;
    logic [15:0] offset_ms;

    modport source (output valid, op, now_ms, task_id, elapsed_us, interval_ms, offset_ms,
                    input ready);
    modport sink   (input valid, op, now_ms, task_id, elapsed_us, interval_ms, offset_ms,
                    output ready);
endinterface

interface pdt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        due_found;
    logic [2:0]  due_task;
    logic        overrun_now;
    logic [6:0]  cpu_pct;
    logic [31:0] run_count;
    logic [31:0] last_run_us;
    logic [31:0] worst_run_us;
    logic [31:0] overrun_count;
    logic [3:0]  slot_count;

    modport source (output valid, status, due_found, due_task, overrun_now, cpu_pct,
                    run_count, last_run_us, worst_run_us, overrun_count, slot_count,
                    input ready);
    modport sink   (input valid, status, due_found, due_task, overrun_now, cpu_pct,
                    run_count, last_run_us, worst_run_us, overrun_count, slot_count,
                    output ready);
endinterface

>>> design/pdt_ctrl.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher controller
// Sequences one op through scan, finish, window and divide steps.
// ----------------------------------------------------------------------------
module pdt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pdt_pkg::t_sts i_sts,
    output pdt_pkg::t_cmd o_cmd
);
    import pdt_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_SCAN   = 10'b00_0000_0100,
        S_FIN1   = 10'b00_0000_1000,
        S_FIN2   = 10'b00_0001_0000,
        S_WMUL   = 10'b00_0010_0000,
        S_W101   = 10'b00_0100_0000,
        S_WCMP   = 10'b00_1000_0000,
        S_DIV    = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec = 1'b1;
                case (i_sts.op)
                    OP_POLL:   n_state = S_SCAN;
                    OP_FINISH: n_state = i_sts.id_valid ? S_FIN1 : S_DONE;
                    OP_WINDOW: n_state = S_WMUL;
                    default:   n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state    = S_FIN2;
            end
            S_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state    = S_DONE;
            end
            S_WMUL: begin
                o_cmd.wmul = 1'b1;
                n_state    = i_sts.win_short ? S_DONE : S_W101;
            end
            S_W101: begin
                o_cmd.w101 = 1'b1;
                n_state    = S_WCMP;
            end
            S_WCMP: begin
                o_cmd.wcmp = 1'b1;
                n_state    = i_sts.win_fin ? S_DONE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (!i_sts.out_busy) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/pdt_dp.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher datapath
// Slot table, statistics, window divider and the result register.
// ----------------------------------------------------------------------------
module pdt_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pdt_pkg::t_cmd i_cmd,
    output pdt_pkg::t_sts o_sts,
    input  logic [2:0]    i_op,
    input  logic [31:0]   i_now_ms,
    input  logic [2:0]    i_task_id,
    input  logic [31:0]   i_elapsed_us,
    input  logic [15:0]   i_interval_ms,
    input  logic [15:0]   i_offset_ms,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic          o_due_found,
    output logic [2:0]    o_due_task,
    output logic          o_overrun_now,
    output logic [6:0]    o_cpu_pct,
    output logic [31:0]   o_run_count,
    output logic [31:0]   o_last_run_us,
    output logic [31:0]   o_worst_run_us,
    output logic [31:0]   o_overrun_count,
    output logic [3:0]    o_slot_count
);
    import pdt_pkg::*;

    localparam logic [2:0] DIV_TOP = 3'(PCT_W - 1);

    // Latched op beat.
    logic [2:0]        r_op;
    logic [31:0]       r_now, r_dt;
    logic [SLOT_W-1:0] r_id;
    logic [15:0]       r_per, r_phase;

    // Slot table.
    logic [15:0]          r_period [MAX_SLOTS];
    logic [31:0]          r_due    [MAX_SLOTS];
    logic [31:0]          r_runs   [MAX_SLOTS];
    logic [31:0]          r_last   [MAX_SLOTS];
    logic [31:0]          r_worst  [MAX_SLOTS];
    logic [31:0]          r_ovr    [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_stat_ok;

    logic [CNT_W-1:0] r_used, r_scan;
    logic [31:0]      r_busy, r_wstart;
    logic [PCT_W-1:0] r_pct;

    // Window divider.
    logic [31:0]       r_win;
    logic [PROD_W-1:0] r_prod, r_win101, r_rem;
    logic [PCT_W-1:0]  r_q;
    logic [2:0]        r_k;

    // Pending result.
    t_status     r_res_status;
    logic        r_res_found, r_res_over;
    logic [2:0]  r_res_task;
    logic [31:0] r_res_runs, r_res_last, r_res_worst, r_res_ovr;

    logic        r_out_valid;
    logic [1:0]  r_o_status;
    logic        r_o_found, r_o_over;
    logic [2:0]  r_o_task;
    logic [6:0]  r_o_pct;
    logic [31:0] r_o_runs, r_o_last, r_o_worst, r_o_ovr;
    logic [3:0]  r_o_count;

    logic              id_valid, full;
    logic [SLOT_W-1:0] scan_idx;
    logic              scan_in, scan_hit;
    logic [31:0]       scan_gap;
    logic [15:0]       cur_per;
    logic [31:0]       cur_due, cur_runs, cur_last, cur_worst, cur_ovr;
    logic [25:0]       per_us;
    logic              fin_over;
    logic [17:0]       late_lim;
    logic [31:0]       late_gap;
    logic              realign;
    logic [31:0]       span;
    logic              win_short, win_fin;
    logic [PROD_W-1:0] trial;
    logic              div_fit;
    logic [PCT_W-1:0]  q_next;
    logic              win_commit;
    logic [PCT_W-1:0]  win_pct;

    assign id_valid = {1'b0, r_id} < r_used;
    assign full     = r_used >= CNT_W'(MAX_SLOTS);

    assign scan_idx = r_scan[SLOT_W-1:0];
    assign scan_in  = r_scan < r_used;
    assign scan_gap = r_now - r_due[scan_idx];
    assign scan_hit = scan_in && (r_period[scan_idx] != 16'd0) && !scan_gap[31];

    // Statistics never written since reset read as zero.
    assign cur_per   = r_period[r_id];
    assign cur_due   = r_due[r_id];
    assign cur_runs  = r_stat_ok[r_id] ? r_runs[r_id]  : 32'd0;
    assign cur_last  = r_stat_ok[r_id] ? r_last[r_id]  : 32'd0;
    assign cur_worst = r_stat_ok[r_id] ? r_worst[r_id] : 32'd0;
    assign cur_ovr   = r_stat_ok[r_id] ? r_ovr[r_id]   : 32'd0;

    assign per_us   = 26'(cur_per) * 26'(MS_TO_US);
    assign fin_over = r_dt > 32'(per_us);

    // A task more than three periods late has its deadline realigned to now plus one period.
    assign late_lim = 18'(cur_per) * 18'(LATE_PERIODS);
    assign late_gap = r_now - cur_due;
    assign realign  = !late_gap[31] && (late_gap > 32'(late_lim));

    assign span      = r_now - r_wstart;
    assign win_short = span < 32'(WIN_MIN_MS);
    // Quotient of 101 or more saturates, so the divider needs only seven steps.
    assign win_fin   = (r_win == 32'd0) || (r_prod >= r_win101);

    assign trial   = PROD_W'(r_win) << r_k;
    assign div_fit = r_rem >= trial;
    assign q_next  = r_q | (PCT_W'(div_fit) << r_k);

    always_comb begin
        win_commit = 1'b0;
        win_pct    = '0;
        if (i_cmd.wcmp && win_fin) begin
            win_commit = 1'b1;
            win_pct    = (r_win == 32'd0) ? '0 : PCT_W'(PCT_FULL);
        end else if (i_cmd.div && (r_k == 3'd0)) begin
            win_commit = 1'b1;
            win_pct    = q_next;
        end
    end

    assign o_sts.op        = t_op'(r_op);
    assign o_sts.id_valid  = id_valid;
    assign o_sts.scan_done = scan_hit || !scan_in;
    assign o_sts.win_short = win_short;
    assign o_sts.win_fin   = win_fin;
    assign o_sts.div_last  = (r_k == 3'd0);
    assign o_sts.out_busy  = r_out_valid && !i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_stat_ok   <= '0;
            r_busy      <= '0;
            r_wstart    <= '0;
            r_pct       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec && (t_op'(r_op) == OP_ADD) && !full) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (i_cmd.fin1) begin
                r_stat_ok[r_id] <= 1'b1;
                r_busy          <= r_busy + r_dt;
            end
            if (win_commit) begin
                r_pct    <= win_pct;
                r_busy   <= '0;
                r_wstart <= r_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_op;
            r_now        <= i_now_ms;
            r_id         <= i_task_id;
            r_dt         <= i_elapsed_us;
            r_per        <= i_interval_ms;
            r_phase      <= i_offset_ms;
            r_res_status <= ST_OK;
            r_res_found  <= 1'b0;
            r_res_task   <= '0;
            r_res_over   <= 1'b0;
            r_res_runs   <= '0;
            r_res_last   <= '0;
            r_res_worst  <= '0;
            r_res_ovr    <= '0;
        end
        if (i_cmd.exec) begin
            case (t_op'(r_op))
                OP_POLL: r_scan <= CNT_W'(r_id);
                OP_FINISH: begin
                    if (!id_valid) begin
                        r_res_status <= ST_INVALID;
                    end
                end
                OP_ADD: begin
                    if (full) begin
                        r_res_status <= ST_FULL;
                    end else begin
                        r_period[r_used[SLOT_W-1:0]] <= r_per;
                        r_due[r_used[SLOT_W-1:0]]    <= r_now + 32'(r_phase);
                        r_res_task                   <= r_used[SLOT_W-1:0];
                    end
                end
                OP_SETPER: begin
                    if (!id_valid) begin
                        r_res_status <= ST_INVALID;
                    end else begin
                        r_period[r_id] <= r_per;
                        if (r_per != 16'd0) begin
                            r_due[r_id] <= r_now + 32'(r_per);
                        end
                    end
                end
                OP_READ: begin
                    if (!id_valid) begin
                        r_res_status <= ST_INVALID;
                    end else begin
                        r_res_runs  <= cur_runs;
                        r_res_last  <= cur_last;
                        r_res_worst <= cur_worst;
                        r_res_ovr   <= cur_ovr;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.scan) begin
            if (scan_hit) begin
                r_res_found <= 1'b1;
                r_res_task  <= scan_idx;
            end else begin
                r_scan <= r_scan + CNT_W'(1);
            end
        end
        if (i_cmd.fin1) begin
            r_runs[r_id]  <= cur_runs + 32'd1;
            r_last[r_id]  <= r_dt;
            r_worst[r_id] <= (r_dt > cur_worst) ? r_dt : cur_worst;
            r_ovr[r_id]   <= fin_over ? cur_ovr + 32'd1 : cur_ovr;
            r_due[r_id]   <= cur_due + 32'(cur_per);
            r_res_over    <= fin_over;
        end
        if (i_cmd.fin2) begin
            if (realign) begin
                r_due[r_id] <= r_now + 32'(cur_per);
            end
            r_res_runs  <= cur_runs;
            r_res_last  <= cur_last;
            r_res_worst <= cur_worst;
            r_res_ovr   <= cur_ovr;
        end
        if (i_cmd.wmul) begin
            r_win  <= span * 32'(MS_TO_US);
            r_prod <= PROD_W'(r_busy) * PROD_W'(PCT_FULL);
        end
        if (i_cmd.w101) begin
            r_win101 <= PROD_W'(r_win) * PROD_W'(PCT_FULL + 1);
        end
        if (i_cmd.wcmp) begin
            r_rem <= r_prod;
            r_q   <= '0;
            r_k   <= DIV_TOP;
        end
        if (i_cmd.div) begin
            if (div_fit) begin
                r_rem <= r_rem - trial;
            end
            r_q <= q_next;
            r_k <= r_k - 3'd1;
        end
        if (i_cmd.publish) begin
            r_o_status <= r_res_status;
            r_o_found  <= r_res_found;
            r_o_task   <= r_res_task;
            r_o_over   <= r_res_over;
            r_o_pct    <= r_pct;
            r_o_runs   <= r_res_runs;
            r_o_last   <= r_res_last;
            r_o_worst  <= r_res_worst;
            r_o_ovr    <= r_res_ovr;
            r_o_count  <= r_used;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_o_status;
    assign o_due_found     = r_o_found;
    assign o_due_task      = r_o_task;
    assign o_overrun_now   = r_o_over;
    assign o_cpu_pct       = r_o_pct;
    assign o_run_count     = r_o_runs;
    assign o_last_run_us   = r_o_last;
    assign o_worst_run_us  = r_o_worst;
    assign o_overrun_count = r_o_ovr;
    assign o_slot_count    = r_o_count;

endmodule

>>> design/periodic_task_dispatcher_top.sv
// Every op passes decode and done; finish on an added slot also passes fin1 and fin2,
// poll scans slots from the given id until a due slot or the table end, and a window
// close passes the multiply step, unless short the scale and compare steps, and unless
// saturated or empty the seven-step divider. One op is in flight at a time; the next
// beat is taken the cycle after the result is registered, and a stalled result delays it.
// Synchronous active-low reset clears the sequencer, slot count, window and stat flags.
// ----------------------------------------------------------------------------
// Periodic task dispatcher top level
// Joins the op sequencer and the slot datapath to the two channels.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_top (
    input logic        i_clk,
    input logic        i_rst_n,
    pdt_in_if.sink     i_task,
    pdt_out_if.source  o_res
);
    import pdt_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ready;

    assign i_task.ready = ready;

    pdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_task.valid),
        .o_ready (ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pdt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_task.op),
        .i_now_ms        (i_task.now_ms),
        .i_task_id       (i_task.task_id),
        .i_elapsed_us    (i_task.elapsed_us),
        .i_interval_ms   (i_task.interval_ms),
        .i_offset_ms     (i_task.offset_ms),
        .i_ready         (o_res.ready),
        .o_valid         (o_res.valid),
        .o_status        (o_res.status),
        .o_due_found     (o_res.due_found),
        .o_due_task      (o_res.due_task),
        .o_overrun_now   (o_res.overrun_now),
        .o_cpu_pct       (o_res.cpu_pct),
        .o_run_count     (o_res.run_count),
        .o_last_run_us   (o_res.last_run_us),
        .o_worst_run_us  (o_res.worst_run_us),
        .o_overrun_count (o_res.overrun_count),
        .o_slot_count    (o_res.slot_count)
    );

endmodule

>>> design/pdt_checker.sv
// ----------------------------------------------------------------------------
// Periodic task dispatcher port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "periodic_task_dispatcher_top_defines.svh"

module pdt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [6:0] i_cpu_pct,
    input logic [3:0] i_slot_count
);
    import pdt_pkg::*;

    // A result beat waits until the sink takes it.
    `PDT_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    // Only one op is in flight, so two beats are never taken back to back.
    `PDT_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    // Percentage saturates, slot count never passes the table size and status is a known code.
    `PDT_ASSERT(a_ranges, i_clk, i_rst_n,
        i_out_valid |-> (i_cpu_pct <= 7'(PCT_FULL)) && (i_slot_count <= 4'(MAX_SLOTS))
        && (i_status != 2'd3))
    `PDT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind periodic_task_dispatcher_top pdt_checker u_pdt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_task.valid),
    .i_in_ready   (i_task.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_status     (o_res.status),
    .i_cpu_pct    (o_res.cpu_pct),
    .i_slot_count (o_res.slot_count)
);

>>> sim/tb_periodic_task_dispatcher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic task dispatcher testbench
// Drives op beats through the task channel and compares every result beat
// with a cycle-free software image of the slot table, using a bursty sender
// and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_periodic_task_dispatcher_top;
    import pdt_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [1:0]  status;
        logic        due_found;
        logic [2:0]  due_task;
        logic        overrun_now;
        logic [6:0]  cpu_pct;
        logic [31:0] run_count;
        logic [31:0] last_run_us;
        logic [31:0] worst_run_us;
        logic [31:0] overrun_count;
        logic [3:0]  slot_count;
    } t_answer;

    logic clk;
    logic rst_n;

    pdt_in_if  task_if ();
    pdt_out_if res_if ();

    periodic_task_dispatcher_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_task  (task_if),
        .o_res   (res_if)
    );

    // Image of the slot table.
    logic [15:0] img_period [MAX_SLOTS];
    logic [31:0] img_due    [MAX_SLOTS];
    logic [31:0] img_runs   [MAX_SLOTS];
    logic [31:0] img_last   [MAX_SLOTS];
    logic [31:0] img_worst  [MAX_SLOTS];
    logic [31:0] img_ovr    [MAX_SLOTS];
    int          img_used;
    logic [31:0] img_busy;
    logic [31:0] img_win_start;
    logic [6:0]  img_pct;

    t_answer answer_q [$];
    int      errors;
    int      burst_left;
    int      idle_count;
    logic [31:0] tick_now;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit tick_due(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic void dispatch_step(input logic [2:0] op, input logic [31:0] now,
                                          input logic [2:0] id, input logic [31:0] dt,
                                          input logic [15:0] per, input logic [15:0] ph);
        t_answer     a;
        bit          ok_id;
        bit          show;
        logic [31:0] span;
        logic [31:0] win_us;
        logic [31:0] lag;
        logic [63:0] ratio;
        a = '{default: '0};
        ok_id = id < img_used;
        show = 0;
        case (op)
            OP_POLL: begin
                for (int i = id; i < img_used; i++) begin
                    if (img_period[i] != 0 && tick_due(now, img_due[i])) begin
                        a.due_found = 1'b1;
                        a.due_task = i[2:0];
                        break;
                    end
                end
            end
            OP_FINISH: begin
                if (!ok_id) begin
                    a.status = ST_INVALID;
                end else begin
                    img_runs[id] = img_runs[id] + 1;
                    img_last[id] = dt;
                    if (dt > img_worst[id]) img_worst[id] = dt;
                    if (dt > 32'(img_period[id]) * MS_TO_US) begin
                        img_ovr[id] = img_ovr[id] + 1;
                        a.overrun_now = 1'b1;
                    end
                    img_busy = img_busy + dt;
                    img_due[id] = img_due[id] + 32'(img_period[id]);
                    lag = now - img_due[id];
                    if (!lag[31] && lag > 32'(img_period[id]) * LATE_PERIODS)
                        img_due[id] = now + 32'(img_period[id]);
                    show = 1;
                end
            end
            OP_WINDOW: begin
                span = now - img_win_start;
                if (span >= WIN_MIN_MS) begin
                    win_us = span * MS_TO_US;
                    ratio = 0;
                    if (win_us != 0) ratio = ({32'd0, img_busy} * PCT_FULL) / {32'd0, win_us};
                    img_pct = (ratio > PCT_FULL) ? 7'(PCT_FULL) : ratio[6:0];
                    img_busy = 0;
                    img_win_start = now;
                end
            end
            OP_ADD: begin
                if (img_used >= MAX_SLOTS) begin
                    a.status = ST_FULL;
                end else begin
                    img_period[img_used] = per;
                    img_due[img_used] = now + 32'(ph);
                    a.due_task = img_used[2:0];
                    img_used++;
                end
            end
            OP_SETPER: begin
                if (!ok_id) begin
                    a.status = ST_INVALID;
                end else begin
                    img_period[id] = per;
                    if (per != 0) img_due[id] = now + 32'(per);
                end
            end
            OP_READ: begin
                if (!ok_id) a.status = ST_INVALID;
                else show = 1;
            end
            default: ;
        endcase
        if (show) begin
            a.run_count = img_runs[id];
            a.last_run_us = img_last[id];
            a.worst_run_us = img_worst[id];
            a.overrun_count = img_ovr[id];
        end
        a.cpu_pct = img_pct;
        a.slot_count = 4'(img_used);
        answer_q.push_back(a);
    endfunction

    task automatic send_op(input logic [2:0] op, input logic [31:0] now, input logic [2:0] id,
                           input logic [31:0] dt, input logic [15:0] per,
                           input logic [15:0] ph);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                task_if.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        task_if.valid       <= 1'b1;
        task_if.op          <= op;
        task_if.now_ms      <= now;
        task_if.task_id     <= id;
        task_if.elapsed_us  <= dt;
        task_if.interval_ms <= per;
        task_if.offset_ms   <= ph;
        do @(posedge clk); while (!task_if.ready);
        dispatch_step(op, now, id, dt, per, ph);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    // Result checker.
    always @(posedge clk) begin
        t_answer w;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected result beat", 0, 0);
            end else begin
                w = answer_q.pop_front();
                if (res_if.status !== w.status) report_mismatch("status", res_if.status, w.status);
                if (res_if.due_found !== w.due_found)
                    report_mismatch("due_found", res_if.due_found, w.due_found);
                if (res_if.due_task !== w.due_task)
                    report_mismatch("due_task", res_if.due_task, w.due_task);
                if (res_if.overrun_now !== w.overrun_now)
                    report_mismatch("overrun_now", res_if.overrun_now, w.overrun_now);
                if (res_if.cpu_pct !== w.cpu_pct)
                    report_mismatch("cpu_pct", res_if.cpu_pct, w.cpu_pct);
                if (res_if.run_count !== w.run_count)
                    report_mismatch("run_count", res_if.run_count, w.run_count);
                if (res_if.last_run_us !== w.last_run_us)
                    report_mismatch("last_run_us", res_if.last_run_us, w.last_run_us);
                if (res_if.worst_run_us !== w.worst_run_us)
                    report_mismatch("worst_run_us", res_if.worst_run_us, w.worst_run_us);
                if (res_if.overrun_count !== w.overrun_count)
                    report_mismatch("overrun_count", res_if.overrun_count, w.overrun_count);
                if (res_if.slot_count !== w.slot_count)
                    report_mismatch("slot_count", res_if.slot_count, w.slot_count);
            end
        end
    end

    // Receiver: stalls of random length, with quiet stretches where it never stalls.
    initial begin
        int stall_left;
        int quiet_left;
        stall_left = 0;
        quiet_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (quiet_left > 0) begin
                quiet_left--;
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                case ($urandom_range(0, 9))
                    0: quiet_left = $urandom_range(20, 200);
                    1, 2, 3: stall_left = $urandom_range(1, 20);
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((task_if.valid && task_if.ready) || (res_if.valid && res_if.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_empty_table;
        send_op(OP_READ, 0, 0, 0, 0, 0);
        send_op(OP_POLL, 0, 0, 0, 0, 0);
        send_op(OP_SPARE6, '1, '1, '1, '1, '1);
        send_op(OP_SPARE7, 32'h1234_5678, 3'd5, 32'hDEAD_BEEF, 16'hA5A5, 16'h5A5A);
    endtask

    task automatic test_add_slots;
        send_op(OP_ADD, 0, 0, 0, 16'd0, 16'd0);
        send_op(OP_ADD, 32'hFFFF_FFFF, 0, 0, 16'hFFFF, 16'hFFFF);
        send_op(OP_ADD, 32'd100, 0, 0, 16'd10, 16'd5);
    endtask

    task automatic test_invalid_slot;
        send_op(OP_FINISH, 32'd100, 3'd3, 32'd50, 0, 0);
        send_op(OP_SETPER, 32'd100, 3'd7, 0, 16'd20, 0);
        send_op(OP_READ, 32'd100, 3'd3, 0, 0, 0);
    endtask

    task automatic test_finish_cases;
        send_op(OP_FINISH, 32'd105, 3'd2, 32'd10001, 0, 0);
        // More than three periods late, so the deadline is realigned.
        send_op(OP_FINISH, 32'd1000, 3'd2, 32'hFFFF_FFFF, 0, 0);
        send_op(OP_FINISH, 32'd50, 3'd0, 32'd0, 0, 0);
        send_op(OP_READ, 32'd50, 3'd2, 0, 0, 0);
    endtask

    task automatic test_poll_cases;
        send_op(OP_POLL, 32'd1000, 3'd0, 0, 0, 0);
        send_op(OP_POLL, 32'd1010, 3'd0, 0, 0, 0);
        send_op(OP_POLL, 32'd5000, 3'd7, 0, 0, 0);
        send_op(OP_SETPER, 32'd2000, 3'd0, 0, 16'd5, 0);
        send_op(OP_POLL, 32'd2005, 3'd0, 0, 0, 0);
    endtask

    task automatic test_window_cases;
        send_op(OP_WINDOW, 32'd500, 0, 0, 0, 0);
        send_op(OP_WINDOW, 32'd1000, 0, 0, 0, 0);
        // A span of 2^29 ms wraps the window length in microseconds to zero.
        send_op(OP_WINDOW, 32'd1000 + 32'h2000_0000, 0, 0, 0, 0);
    endtask

    task automatic test_table_full;
        while (img_used < MAX_SLOTS)
            send_op(OP_ADD, $urandom, 0, 0, 16'($urandom_range(1, 40)), 16'($urandom_range(0, 50)));
        send_op(OP_ADD, 32'd7, 0, 0, 16'd3, 16'd3);
    endtask

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 50));
        endcase
    endfunction

    task automatic test_random_traffic(input int count);
        int          pick;
        logic [2:0]  id;
        logic [31:0] dt;
        logic [31:0] now;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 3) tick_now = $urandom;
            else tick_now = tick_now + $urandom_range(0, 300);
            now = tick_now;
            pick = $urandom_range(0, 99);
            id = (img_used > 0 && $urandom_range(0, 4) != 0) ?
                 3'($urandom_range(0, img_used - 1)) : 3'($urandom_range(0, 7));
            if (pick < 35) begin
                send_op(OP_POLL, now, 3'($urandom_range(0, 7)), $urandom, 16'($urandom),
                        16'($urandom));
            end else if (pick < 65) begin
                if ($urandom_range(0, 9) == 0 || id >= img_used) dt = $urandom;
                else dt = $urandom_range(0, img_period[id] * 1100 + 50);
                send_op(OP_FINISH, now, id, dt, 16'($urandom), 16'($urandom));
            end else if (pick < 72) begin
                if ($urandom_range(0, 9) == 0) now = $urandom;
                send_op(OP_WINDOW, now, 3'($urandom), $urandom, 16'($urandom), 16'($urandom));
            end else if (pick < 76) begin
                send_op(OP_ADD, now, 3'($urandom), $urandom, pick_period(),
                        $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 60)));
            end else if (pick < 86) begin
                send_op(OP_SETPER, now, id, $urandom, pick_period(), 16'($urandom));
            end else if (pick < 96) begin
                send_op(OP_READ, now, id, $urandom, 16'($urandom), 16'($urandom));
            end else begin
                send_op($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, $urandom, 3'($urandom),
                        $urandom, 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        int waited;
        errors = 0;
        burst_left = 0;
        idle_count = 0;
        tick_now = 32'd3000;
        img_used = 0;
        img_busy = 0;
        img_win_start = 0;
        img_pct = 0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            img_period[i] = 0;
            img_due[i] = 0;
            img_runs[i] = 0;
            img_last[i] = 0;
            img_worst[i] = 0;
            img_ovr[i] = 0;
        end
        rst_n = 1'b0;
        task_if.valid = 1'b0;
        task_if.op = OP_POLL;
        task_if.now_ms = 0;
        task_if.task_id = 0;
        task_if.elapsed_us = 0;
        task_if.interval_ms = 0;
        task_if.offset_ms = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_add_slots();
        test_invalid_slot();
        test_finish_cases();
        test_poll_cases();
        test_window_cases();
        test_random_traffic(40);
        test_table_full();
        test_random_traffic(710);

        @(negedge clk);
        task_if.valid <= 1'b0;
        waited = 0;
        while (answer_q.size() != 0 && waited < IDLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
